// File: rtl/core/rc4_pkg.sv
// rc4_pkg: shared types and constants for the RC4 stream cipher unit.
// Depends on nothing; used by the top level, the engine and the checker.
package rc4_pkg;

    localparam int BYTE_W     = 8;
    localparam int PERM_DEPTH = 256;
    localparam int ADDR_W     = 8;
    localparam int KEY_W      = 64;
    localparam int KEY_IDX_W  = 4;
    localparam int KEY_SEL_W  = KEY_IDX_W + 3;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              start_message;
    } rc4_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic [BYTE_W-1:0] keystream_byte;
    } rc4_out_t;

    // top level to engine
    typedef struct packed {
        logic start;
        logic rekey;
        logic out_free;
    } rc4_cmd_t;

    // engine to top level
    typedef struct packed {
        logic              idle;
        logic              done;
        logic [BYTE_W-1:0] ks;
    } rc4_sts_t;

endpackage

// File: rtl/core/rc4_engine.sv
// rc4_engine: permutation memory, index registers and the swap sequencer.
// Depends on rc4_pkg.
module rc4_engine #(
    parameter int KEY_BYTES = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rc4_pkg::rc4_cmd_t             cmd,
    input  logic [2*rc4_pkg::KEY_W-1:0]   key,
    output rc4_pkg::rc4_sts_t             sts
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_RD_I = 3'd2;
    localparam logic [2:0] ST_RD_J = 3'd3;
    localparam logic [2:0] ST_WR_I = 3'd4;
    localparam logic [2:0] ST_WR_J = 3'd5;
    localparam logic [2:0] ST_HOLD = 3'd6;

    localparam logic [rc4_pkg::KEY_IDX_W-1:0] KIDX_LAST =
        rc4_pkg::KEY_IDX_W'(KEY_BYTES - 1);
    localparam logic [rc4_pkg::ADDR_W-1:0] ADDR_LAST =
        rc4_pkg::ADDR_W'(rc4_pkg::PERM_DEPTH - 1);

    logic [rc4_pkg::BYTE_W-1:0] perm_mem [rc4_pkg::PERM_DEPTH];

    logic [2:0]                    state_reg, state_next;
    logic                          ksa_reg, ksa_next;
    logic [rc4_pkg::ADDR_W-1:0]    i_reg, i_next;
    logic [rc4_pkg::ADDR_W-1:0]    j_reg, j_next;
    logic [rc4_pkg::KEY_IDX_W-1:0] kidx_reg, kidx_next;
    logic [rc4_pkg::BYTE_W-1:0]    si_reg, si_next;
    logic [rc4_pkg::BYTE_W-1:0]    sj_reg, sj_next;
    logic [rc4_pkg::ADDR_W-1:0]    t_reg, t_next;
    logic [rc4_pkg::BYTE_W-1:0]    ks_reg, ks_next;

    logic                          we;
    logic [rc4_pkg::ADDR_W-1:0]    waddr;
    logic [rc4_pkg::BYTE_W-1:0]    wdata;
    logic [rc4_pkg::ADDR_W-1:0]    raddr;
    logic [rc4_pkg::BYTE_W-1:0]    rdata_reg;

    logic [rc4_pkg::BYTE_W-1:0]    key_byte;
    logic [rc4_pkg::BYTE_W-1:0]    key_add;
    logic [rc4_pkg::ADDR_W-1:0]    j_sum;
    logic [rc4_pkg::BYTE_W-1:0]    ks_fwd;
    logic                          done;
    logic [rc4_pkg::BYTE_W-1:0]    ks_out;

    always_ff @(posedge aclk) begin
        if (we) begin
            perm_mem[waddr] <= wdata;
        end
        rdata_reg <= perm_mem[raddr];
    end

    assign key_byte = key[{kidx_reg, 3'b000} +: rc4_pkg::BYTE_W];
    assign key_add  = ksa_reg ? key_byte : '0;
    // the adder path for j: j + S[i] (+ key byte while scheduling)
    assign j_sum    = j_reg + rdata_reg + key_add;

    // keystream read of S[t] was issued before the swap landed: forward
    always_comb begin
        if (t_reg == j_reg) begin
            ks_fwd = si_reg;
        end else if (t_reg == i_reg) begin
            ks_fwd = sj_reg;
        end else begin
            ks_fwd = rdata_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        ksa_next   = ksa_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        kidx_next  = kidx_reg;
        si_next    = si_reg;
        sj_next    = sj_reg;
        t_next     = t_reg;
        ks_next    = ks_reg;
        we         = 1'b0;
        waddr      = i_reg;
        wdata      = i_reg;
        raddr      = i_reg;
        done       = 1'b0;
        ks_out     = ks_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.start) begin
                    if (cmd.rekey) begin
                        ksa_next   = 1'b1;
                        i_next     = '0;
                        j_next     = '0;
                        kidx_next  = '0;
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_RD_I;
                    end
                end
            end
            ST_FILL: begin
                we     = 1'b1;
                i_next = i_reg + 1'b1;
                if (i_reg == ADDR_LAST) begin
                    state_next = ST_RD_I;
                end
            end
            ST_RD_I: begin
                if (ksa_reg) begin
                    raddr = i_reg;
                end else begin
                    raddr  = i_reg + 1'b1;
                    i_next = i_reg + 1'b1;
                end
                state_next = ST_RD_J;
            end
            ST_RD_J: begin
                si_next    = rdata_reg;
                j_next     = j_sum;
                raddr      = j_sum;
                state_next = ST_WR_I;
            end
            ST_WR_I: begin
                we         = 1'b1;
                waddr      = i_reg;
                wdata      = rdata_reg;
                sj_next    = rdata_reg;
                t_next     = si_reg + rdata_reg;
                raddr      = si_reg + rdata_reg;
                state_next = ST_WR_J;
            end
            ST_WR_J: begin
                we    = 1'b1;
                waddr = j_reg;
                wdata = si_reg;
                if (ksa_reg) begin
                    i_next     = i_reg + 1'b1;
                    kidx_next  = (kidx_reg == KIDX_LAST) ? '0 : kidx_reg + 1'b1;
                    state_next = ST_RD_I;
                    if (i_reg == ADDR_LAST) begin
                        ksa_next = 1'b0;
                        j_next   = '0;
                    end
                end else if (cmd.out_free) begin
                    done       = 1'b1;
                    ks_out     = ks_fwd;
                    state_next = ST_IDLE;
                end else begin
                    ks_next    = ks_fwd;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (cmd.out_free) begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ksa_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            kidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ksa_reg   <= ksa_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            kidx_reg  <= kidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        si_reg <= si_next;
        sj_reg <= sj_next;
        t_reg  <= t_next;
        ks_reg <= ks_next;
    end

    assign sts.idle = (state_reg == ST_IDLE);
    assign sts.done = done;
    assign sts.ks   = ks_out;

endmodule

// File: rtl/core/rc4_stream_cipher_unit.sv
// rc4_stream_cipher_unit: top level of the RC4 stream cipher.
// Depends on rc4_pkg and rc4_engine.
//
// Each accepted transaction on the s_ channel yields exactly one m_ transaction carrying
// data_byte XOR the next RC4 keystream byte, plus that keystream byte. A transaction
// with start_message set first reruns the key schedule with the key held in the two
// key registers (cfg_index 0 = key bytes 0..7, 1 = key bytes 8..15, byte 0 in the low
// bits; other indexes are dropped), using key bytes 0..KEY_BYTES-1 cyclically.
// The step sequence follows from the 256-byte permutation memory, which has one read
// port and one write port: every swap needs two dependent reads and two writes, and the
// key schedule first fills the memory with the identity one entry per cycle. s_ready is
// low while a byte is in work. The result register lets the next byte be accepted while
// a result still waits on m_ready; a finished byte holds in the engine until the result
// register frees up. The first byte after reset must carry start_message: the
// permutation is unknown until then. Write the key registers only while the unit is
// idle; they take effect at the next key schedule.
module rc4_stream_cipher_unit #(
    parameter int KEY_BYTES = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  rc4_pkg::rc4_in_t                s_data,

    output logic                            m_valid,
    input  logic                            m_ready,
    output rc4_pkg::rc4_out_t               m_data,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rc4_pkg::KEY_W-1:0]       cfg_data
);

    logic [rc4_pkg::KEY_W-1:0]  key_low_reg;
    logic [rc4_pkg::KEY_W-1:0]  key_high_reg;
    logic [rc4_pkg::BYTE_W-1:0] data_reg;
    logic                       m_valid_reg, m_valid_next;
    rc4_pkg::rc4_out_t          m_data_reg;

    rc4_pkg::rc4_cmd_t          cmd;
    rc4_pkg::rc4_sts_t          sts;
    logic                       s_accept;

    // Configuration is always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                rc4_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                rc4_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Accept only when the engine is idle; it runs one byte at a time.
    assign s_ready  = sts.idle;
    assign s_accept = s_valid && s_ready;

    // Hold the data byte for the XOR at the end of the step.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            data_reg <= s_data.data_byte;
        end
    end

    assign cmd.start    = s_accept;
    assign cmd.rekey    = s_data.start_message;
    assign cmd.out_free = !m_valid_reg || m_ready;

    rc4_engine #(
        .KEY_BYTES (KEY_BYTES)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .key     ({key_high_reg, key_low_reg}),
        .sts     (sts)
    );

    // Result register: load on engine completion, drop once taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (sts.done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sts.done) begin
            m_data_reg.result_byte    <= data_reg ^ sts.ks;
            m_data_reg.keystream_byte <= sts.ks;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/rc4_checker.sv
// rc4_checker: port-level assertions for rc4_stream_cipher_unit, with its bind.
// Depends on rc4_pkg and rc4_stream_cipher_unit.
module rc4_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input rc4_pkg::rc4_out_t               m_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // the unit is busy right after taking a byte
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after accept");

    // coming out of reset the unit is idle with no result pending
    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> s_ready && !m_valid)
        else $error("unit not idle after reset");

    // after an accept with no result pending, no result shows up before the engine has read S[i] and S[j]
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid ##1 !m_valid ##1 !m_valid)
        else $error("result came too early");

endmodule

bind rc4_stream_cipher_unit rc4_checker u_rc4_checker (.*);
